// File: design/idd_pkg.sv
// package for the incremental deadlock detector
// holds field widths, parameter defaults, controller state and command/status types
// no dependencies
package idd_pkg;

    // default graph size
    localparam int DEF_MAX_PROCESSES = 32;
    localparam int DEF_MAX_RESOURCES = 32;

    // payload field widths
    localparam int PID_W     = 5;
    localparam int RID_W     = 5;
    localparam int BLOCKED_W = 32;
    localparam int EDGE_NUM_W = 16;

    // edge command codes
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_ASSIGN  = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP_P,
        ST_SWEEP_R,
        ST_EMIT
    } t_idd_state;

    // controller to datapath
    typedef struct packed {
        logic load_edge;
        logic step_p;
        logic step_r;
        logic emit;
    } t_idd_cmd;

    // datapath to controller
    typedef struct packed {
        logic stable;
        logic out_free;
    } t_idd_status;

endpackage

// File: design/idd_edge_if.sv
// input channel of the deadlock detector: one edge per beat
// depends on idd_pkg for field widths
interface idd_edge_if import idd_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             command;
    logic [PID_W-1:0] process_id;
    logic [RID_W-1:0] resource_id;

    modport source (output valid, output command, output process_id, output resource_id,
                    input ready);
    modport sink   (input valid, input command, input process_id, input resource_id,
                    output ready);
endinterface

// File: design/idd_result_if.sv
// output channel of the deadlock detector: one reduction result per beat
// depends on idd_pkg for field widths
interface idd_result_if import idd_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic                  deadlock;
    logic [BLOCKED_W-1:0]  blocked_processes;
    logic [EDGE_NUM_W-1:0] edge_number;

    modport source (output valid, output deadlock, output blocked_processes,
                    output edge_number, input ready);
    modport sink   (input valid, input deadlock, input blocked_processes,
                    input edge_number, output ready);
endinterface

// File: design/incremental_deadlock_detector_core.sv
// top level of the incremental deadlock detector
// depends on idd_pkg, idd_edge_if, idd_result_if, idd_controller, idd_datapath
//
//  channel    dir  beat contents
//  i_edge     in   command, process_id, resource_id
//  o_result   out  deadlock, blocked_processes, edge_number
//
// an edge takes a load step, k reduction passes of a process sweep then a resource sweep,
// and an emit step that waits for a free output slot; k is up to MAX_PROCESSES +
// MAX_RESOURCES + 1, set by the alternating process and resource sweeps over the matrices
// synchronous reset clears both edge matrices and the edge counter
// one edge in flight; a result waiting in the output register holds the next edge
// off only in the emit state, i_edge.ready is high whenever the sequencer is idle
module incremental_deadlock_detector_core import idd_pkg::*; #(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = DEF_MAX_RESOURCES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    idd_edge_if.sink      i_edge,
    idd_result_if.source  o_result
);

    t_idd_cmd    w_cmd;
    t_idd_status w_status;

    // sequencer
    idd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_edge.valid),
        .i_status   (w_status),
        .o_in_ready (i_edge.ready),
        .o_cmd      (w_cmd)
    );

    // matrices and reduction
    idd_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_command           (i_edge.command),
        .i_process_id        (i_edge.process_id),
        .i_resource_id       (i_edge.resource_id),
        .i_out_ready         (o_result.ready),
        .o_status            (w_status),
        .o_out_valid         (o_result.valid),
        .o_deadlock          (o_result.deadlock),
        .o_blocked_processes (o_result.blocked_processes),
        .o_edge_number       (o_result.edge_number)
    );

`ifndef NO_ASSERTIONS
    // an accepted edge keeps the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_edge.valid && i_edge.ready) |=> !i_edge.ready)
        else $error("input ready right after an accepted edge");

    // a result is only loaded when the output slot is free
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_result.valid || o_result.ready))
        else $error("result loaded over a pending beat");

    // deadlock flag agrees with the reported mask when all processes fit in it
    a_flag_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((MAX_PROCESSES > BLOCKED_W) ||
                            (o_result.deadlock == (o_result.blocked_processes != '0))))
        else $error("deadlock flag disagrees with blocked mask");
`endif

endmodule

// File: design/idd_controller.sv
// sequencer of the deadlock detector: edge load, alternating sweeps, result hand-off
// depends on idd_pkg for state, command and status types
module idd_controller import idd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_idd_status i_status,
    output logic        o_in_ready,
    output t_idd_cmd    o_cmd
);

    t_idd_state r_state;
    t_idd_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_edge = 1'b1;
                    n_state         = ST_SWEEP_P;
                end
            end
            ST_SWEEP_P: begin
                o_cmd.step_p = 1'b1;
                n_state      = ST_SWEEP_R;
            end
            ST_SWEEP_R: begin
                o_cmd.step_r = 1'b1;
                // a full pass without change means the fixpoint is reached
                if (i_status.stable) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SWEEP_P;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/idd_datapath.sv
// datapath of the deadlock detector: edge matrices, live sets, edge counter, result register
// depends on idd_pkg for widths and command/status types
module idd_datapath import idd_pkg::*; #(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = DEF_MAX_RESOURCES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_idd_cmd              i_cmd,
    input  logic                  i_command,
    input  logic [PID_W-1:0]      i_process_id,
    input  logic [RID_W-1:0]      i_resource_id,
    input  logic                  i_out_ready,
    output t_idd_status           o_status,
    output logic                  o_out_valid,
    output logic                  o_deadlock,
    output logic [BLOCKED_W-1:0]  o_blocked_processes,
    output logic [EDGE_NUM_W-1:0] o_edge_number
);

    localparam int PIW  = $clog2(MAX_PROCESSES);
    localparam int RIW  = $clog2(MAX_RESOURCES);
    localparam int EXTW = 7;

    // request rows per process, assignment rows per resource
    logic [MAX_RESOURCES-1:0] r_req [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] r_asg [MAX_RESOURCES];

    logic [MAX_PROCESSES-1:0] r_live_p;
    logic [MAX_RESOURCES-1:0] r_live_r;
    logic [MAX_PROCESSES-1:0] n_live_p;
    logic [MAX_RESOURCES-1:0] n_live_r;
    logic                     r_p_changed;

    logic [EDGE_NUM_W-1:0]    r_edge_cnt;
    logic                     r_out_valid;
    logic                     r_deadlock;
    logic [BLOCKED_W-1:0]     r_blocked;
    logic [EDGE_NUM_W-1:0]    r_edge_number;

    logic [EXTW-1:0]          pid_ext;
    logic [EXTW-1:0]          rid_ext;
    logic [PIW-1:0]           p_idx;
    logic [RIW-1:0]           r_idx;
    logic                     edge_ok;
    logic [63:0]              live_p_wide;

    // edge indexes, out-of-range edges are dropped
    assign pid_ext = EXTW'(i_process_id);
    assign rid_ext = EXTW'(i_resource_id);
    assign p_idx   = pid_ext[PIW-1:0];
    assign r_idx   = rid_ext[RIW-1:0];
    assign edge_ok = (pid_ext < EXTW'(MAX_PROCESSES)) && (rid_ext < EXTW'(MAX_RESOURCES));

    // edge matrices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PROCESSES; i++) begin
                r_req[i] <= '0;
            end
            for (int j = 0; j < MAX_RESOURCES; j++) begin
                r_asg[j] <= '0;
            end
        end else if (i_cmd.load_edge && edge_ok) begin
            if (i_command == CMD_REQUEST) begin
                r_req[p_idx][r_idx] <= 1'b1;
            end else begin
                r_asg[r_idx][p_idx] <= 1'b1;
            end
        end
    end

    // process sweep: live process keeps a request to a live resource
    always_comb begin
        for (int i = 0; i < MAX_PROCESSES; i++) begin
            n_live_p[i] = r_live_p[i] && ((r_req[i] & r_live_r) != '0);
        end
    end

    // resource sweep: live resource keeps an assignment to a live process
    always_comb begin
        for (int j = 0; j < MAX_RESOURCES; j++) begin
            n_live_r[j] = r_live_r[j] && ((r_asg[j] & r_live_p) != '0);
        end
    end

    // live sets, restarted full for every edge
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_edge) begin
            r_live_p    <= '1;
            r_live_r    <= '1;
            r_p_changed <= 1'b1;
        end else if (i_cmd.step_p) begin
            r_live_p    <= n_live_p;
            r_p_changed <= (n_live_p != r_live_p);
        end else if (i_cmd.step_r) begin
            r_live_r    <= n_live_r;
        end
    end

    assign o_status.stable   = !r_p_changed && (n_live_r == r_live_r);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // saturating edge counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt <= '0;
        end else if (i_cmd.emit && (r_edge_cnt != '1)) begin
            r_edge_cnt <= r_edge_cnt + EDGE_NUM_W'(1);
        end
    end

    // result register
    assign live_p_wide = 64'(r_live_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_deadlock    <= (r_live_p != '0);
            r_blocked     <= live_p_wide[BLOCKED_W-1:0];
            r_edge_number <= r_edge_cnt;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_deadlock          = r_deadlock;
    assign o_blocked_processes = r_blocked;
    assign o_edge_number       = r_edge_number;

endmodule

// File: sim/tb_incremental_deadlock_detector_core.sv
// self-checking testbench for incremental_deadlock_detector_core: edges in, reduction verdicts out
// depends on idd_pkg, idd_edge_if, idd_result_if and the core with its submodules
// a graph-reduction predictor in a scoreboard class checks every result beat field by field
module tb_incremental_deadlock_detector_core import idd_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PROC          = DEF_MAX_PROCESSES;
    localparam int N_RES           = DEF_MAX_RESOURCES;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 150;
    localparam int STALL_LIMIT     = 3000;
    localparam int MAX_REPORTS     = 100;

    // one predicted reduction verdict
    typedef struct packed {
        logic                  deadlock;
        logic [BLOCKED_W-1:0]  blocked;
        logic [EDGE_NUM_W-1:0] edge_num;
    } t_verdict;

    // graph copy, reduction predictor and verdict checker
    class deadlock_scoreboard;
        bit [N_RES-1:0]        waits_on [N_PROC];
        bit [N_PROC-1:0]       held_by  [N_RES];
        bit [EDGE_NUM_W-1:0]   edge_count;
        t_verdict              pending_verdicts [$];
        int                    edges_seen;
        int                    checked;
        int                    flagged;
        int                    widest;
        int                    errors;

        // strip sinks until stable, what is left is the live process set
        function bit [N_PROC-1:0] surviving_processes();
            bit [N_PROC-1:0] live_p;
            bit [N_PROC-1:0] next_p;
            bit [N_RES-1:0]  live_r;
            bit [N_RES-1:0]  next_r;
            bit              settled;
            live_p = '1;
            live_r = '1;
            do begin
                next_p = '0;
                next_r = '0;
                for (int p = 0; p < N_PROC; p++)
                    next_p[p] = |(waits_on[p] & live_r);
                next_p &= live_p;
                for (int r = 0; r < N_RES; r++)
                    next_r[r] = |(held_by[r] & next_p);
                next_r &= live_r;
                settled = (next_p == live_p) && (next_r == live_r);
                live_p = next_p;
                live_r = next_r;
            end while (!settled);
            return live_p;
        endfunction

        // accepted edge beat: update the graph and queue the verdict
        function void note_edge(logic cmd, logic [PID_W-1:0] pid, logic [RID_W-1:0] rid);
            t_verdict        v;
            bit [N_PROC-1:0] blocked;
            edges_seen++;
            // ids past the graph size are still counted and reduced, just not stored
            if (pid < N_PROC && rid < N_RES) begin
                if (cmd == CMD_REQUEST)
                    waits_on[pid][rid] = 1'b1;
                else
                    held_by[rid][pid] = 1'b1;
            end
            blocked    = surviving_processes();
            v.deadlock = |blocked;
            v.blocked  = BLOCKED_W'(blocked);
            v.edge_num = edge_count;
            pending_verdicts.insert(pending_verdicts.size(), v);
            // counter sticks at all ones
            if (edge_count != '1)
                edge_count++;
        endfunction

        function void report(string field, int unsigned edge_idx,
                             logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch on edge %0d, expected %h, got %h",
                             $time, field, edge_idx, want, got);
            end
        endfunction

        // accepted result beat: compare with the oldest verdict
        function void check_verdict(logic dl, logic [BLOCKED_W-1:0] blk,
                                    logic [EDGE_NUM_W-1:0] num);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got %b %h %h",
                             $time, dl, blk, num);
                return;
            end
            want = pending_verdicts.pop_front();
            checked++;
            if (want.deadlock)
                flagged++;
            if ($countones(want.blocked) > widest)
                widest = $countones(want.blocked);
            report("deadlock", want.edge_num, 32'(want.deadlock), 32'(dl));
            report("blocked_processes", want.edge_num, 32'(want.blocked), 32'(blk));
            report("edge_number", want.edge_num, 32'(want.edge_num), 32'(num));
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    bit   hold_off_req  = 1'b0;

    deadlock_scoreboard verdicts = new();

    idd_edge_if   edge_ch ();
    idd_result_if res_ch ();

    incremental_deadlock_detector_core #(
        .MAX_PROCESSES (N_PROC),
        .MAX_RESOURCES (N_RES)
    ) i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_edge   (edge_ch),
        .o_result (res_ch)
    );

    // 20 ns clock
    always #10 clk = ~clk;

    // beat monitors on both channels
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (edge_ch.valid && edge_ch.ready)
                verdicts.note_edge(edge_ch.command, edge_ch.process_id, edge_ch.resource_id);
            if (res_ch.valid === 1'b1 && res_ch.ready)
                verdicts.check_verdict(res_ch.deadlock, res_ch.blocked_processes,
                                       res_ch.edge_number);
        end
    end

    // result sink: random stalls plus one long hold-off on request
    initial begin : sink_side
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            res_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((edge_ch.valid === 1'b1 && edge_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, verdicts.outstanding());
        $display("Test completed with failures");
        $finish;
    end

    // offer one edge beat, with random idle cycles before it
    task automatic offer_edge(input logic cmd, input logic [PID_W-1:0] pid,
                              input logic [RID_W-1:0] rid);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            edge_ch.valid <= 1'b0;
            @(posedge clk);
        end
        edge_ch.valid       <= 1'b1;
        edge_ch.command     <= cmd;
        edge_ch.process_id  <= pid;
        edge_ch.resource_id <= rid;
        @(posedge clk);
        while (!edge_ch.ready)
            @(posedge clk);
    endtask

    // forward edges (no cycles, long wait chains), except noise_pct percent placed anywhere
    task automatic offer_random_edges(input int count, input int noise_pct);
        logic             cmd;
        logic [PID_W-1:0] pid;
        logic [RID_W-1:0] rid;
        repeat (count) begin
            cmd = logic'($urandom_range(1, 0));
            if ($urandom_range(99, 0) < noise_pct) begin
                pid = PID_W'($urandom_range(N_PROC - 1, 0));
                rid = RID_W'($urandom_range(N_RES - 1, 0));
            end else if (cmd == CMD_REQUEST) begin
                // process i waits on resource j >= i
                pid = PID_W'($urandom_range(N_PROC - 1, 0));
                rid = RID_W'($urandom_range(N_RES - 1, int'(pid)));
            end else begin
                // resource j held by process k > j
                rid = RID_W'($urandom_range(N_RES - 2, 0));
                pid = PID_W'($urandom_range(N_PROC - 1, int'(rid) + 1));
            end
            offer_edge(cmd, pid, rid);
        end
    endtask

    // drop valid and wait until every verdict is back
    task automatic wait_drained();
        edge_ch.valid <= 1'b0;
        @(posedge clk);
        while (verdicts.outstanding() != 0)
            @(posedge clk);
    endtask

    // hand-picked graphs: extreme ids, self loop, two-node cycle, duplicate, deep chain
    task automatic directed_edges();
        // lone request, then holder without a request: nothing blocked
        offer_edge(CMD_REQUEST, 5'd31, 5'd31);
        offer_edge(CMD_ASSIGN,  5'd0,  5'd31);
        // resource 0 held by process 0, which then waits on it: 0 and 31 blocked
        offer_edge(CMD_ASSIGN,  5'd0,  5'd0);
        offer_edge(CMD_REQUEST, 5'd0,  5'd0);
        // cycle through processes 1 and 2
        offer_edge(CMD_REQUEST, 5'd1,  5'd1);
        offer_edge(CMD_ASSIGN,  5'd2,  5'd1);
        offer_edge(CMD_REQUEST, 5'd2,  5'd2);
        offer_edge(CMD_ASSIGN,  5'd1,  5'd2);
        // repeated edge changes nothing
        offer_edge(CMD_ASSIGN,  5'd1,  5'd2);
        // wait chain 3 -> 9, reduces fully and takes many passes
        for (int i = 3; i <= 8; i++) begin
            offer_edge(CMD_REQUEST, PID_W'(i),     RID_W'(i));
            offer_edge(CMD_ASSIGN,  PID_W'(i + 1), RID_W'(i));
        end
        // close the chain into a cycle
        offer_edge(CMD_REQUEST, 5'd9, 5'd3);
    endtask

    // stimulus sequence
    initial begin : stimulus
        edge_ch.valid       <= 1'b0;
        edge_ch.command     <= CMD_REQUEST;
        edge_ch.process_id  <= '0;
        edge_ch.resource_id <= '0;
        rst_n               <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slow sender, slower receiver
        src_idle_pct  = 32;
        sink_idle_pct = 73;
        directed_edges();
        offer_random_edges(210, 5);
        wait_drained();

        // roles swapped, with one long receiver hold-off to back the block up
        src_idle_pct  = 73;
        sink_idle_pct = 32;
        hold_off_req  = 1'b1;
        offer_random_edges(220, 20);
        wait_drained();

        // back to back on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        offer_random_edges(220, 100);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d edges: directed graphs, random graphs under three idle mixes",
                 verdicts.edges_seen);
        $display("%0d verdicts checked, %0d with deadlock, widest blocked set %0d processes",
                 verdicts.checked, verdicts.flagged, verdicts.widest);
        if (verdicts.errors == 0 && verdicts.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
design/idd_pkg.sv
design/idd_edge_if.sv
design/idd_result_if.sv
design/idd_controller.sv
design/idd_datapath.sv
design/incremental_deadlock_detector_core.sv
sim/tb_incremental_deadlock_detector_core.sv
